// ----- rtl/sbdb_pkg.sv -----
// Shared types and constants for the spectrum bin level, smoothing and peak hold block.
// Used by every module of the block; depends on nothing else.
package sbdb_pkg;

    // Display bins and widths.
    localparam int NUM_BINS  = 1024;
    localparam int BIN_W     = 10;

    // Level floor (-100 dB) and 1280*log10(2) in Q16.
    localparam logic signed [15:0] FLOOR_DB = -16'sd12800;
    localparam logic signed [25:0] LOG_K    = 26'sd25252226;

    // Queues and the log2 squaring pipeline.
    localparam int MID_DEPTH = 32;
    localparam int MID_AW    = 5;
    localparam int OUT_DEPTH = 4;
    localparam int OUT_AW    = 2;
    localparam int SQ_STEPS  = 16;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_SMOOTH_COEFF = 3'd0;
    localparam logic [2:0] REG_SLOPE        = 3'd1;
    localparam logic [2:0] REG_PEAK_EN      = 3'd2;
    localparam logic [2:0] REG_HOLD_FRAMES  = 3'd3;
    localparam logic [2:0] REG_DECAY_STEP   = 3'd4;
    localparam logic [2:0] REG_FFT_ORDER    = 3'd5;
    localparam logic [2:0] REG_FIRST_OCT    = 3'd6;
    localparam logic [2:0] REG_OCT_STEP     = 3'd7;

    typedef struct packed {
        logic signed [31:0] re_part;
        logic signed [31:0] im_part;
        logic               frame_end;
    } t_in_item;

    typedef struct packed {
        logic [BIN_W-1:0]   bin_index;
        logic signed [15:0] display_db;
        logic signed [15:0] peak_db;
        logic               frame_done;
    } t_result;

    typedef struct packed {
        logic [15:0]        smooth_coeff;
        logic signed [10:0] slope_per_octave;
        logic               peak_hold_enable;
        logic [8:0]         hold_frames;
        logic [8:0]         decay_step;
        logic [3:0]         fft_order;
        logic signed [20:0] first_octave;
        logic [16:0]        octave_step;
    } t_cfg;

    // Item handed from the front part to the back part.
    typedef struct packed {
        logic [BIN_W-1:0]   bin;
        logic               last;
        logic signed [15:0] level;
        logic signed [33:0] premult;
    } t_mid;

endpackage

// ----- rtl/sbdb_regs.sv -----
// Configuration registers behind the APB-style port.
// Depends on sbdb_pkg for the register indexes and the t_cfg struct.
module sbdb_regs import sbdb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg,
    output logic        o_peak_clr
);

    t_cfg       r_cfg;
    logic       w_wr;
    logic [2:0] w_idx;

    assign pready = 1'b1;
    assign w_idx  = paddr[4:2];
    assign w_wr   = psel && penable && pwrite;

    // A write of zero to the enable register starts a peak clearing pass.
    assign o_peak_clr = w_wr && (w_idx == REG_PEAK_EN) && !pwdata[0];
    assign o_cfg      = r_cfg;

    // Register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.smooth_coeff     <= '0;
            r_cfg.slope_per_octave <= '0;
            r_cfg.peak_hold_enable <= 1'b0;
            r_cfg.hold_frames      <= 9'd60;
            r_cfg.decay_step       <= 9'd64;
            r_cfg.fft_order        <= 4'd12;
            r_cfg.first_octave     <= '0;
            r_cfg.octave_step      <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_SMOOTH_COEFF: r_cfg.smooth_coeff     <= pwdata[15:0];
                REG_SLOPE:        r_cfg.slope_per_octave <= pwdata[10:0];
                REG_PEAK_EN:      r_cfg.peak_hold_enable <= pwdata[0];
                REG_HOLD_FRAMES:  r_cfg.hold_frames      <= pwdata[8:0];
                REG_DECAY_STEP:   r_cfg.decay_step       <= pwdata[8:0];
                REG_FFT_ORDER:    r_cfg.fft_order        <= pwdata[3:0];
                REG_FIRST_OCT:    r_cfg.first_octave     <= pwdata[20:0];
                REG_OCT_STEP:     r_cfg.octave_step      <= pwdata[16:0];
                default:          r_cfg.smooth_coeff     <= r_cfg.smooth_coeff;
            endcase
        end
    end

    // Read-back; signed registers are sign extended.
    always_comb begin
        unique case (w_idx)
            REG_SMOOTH_COEFF: prdata = {16'b0, r_cfg.smooth_coeff};
            REG_SLOPE:        prdata = 32'(r_cfg.slope_per_octave);
            REG_PEAK_EN:      prdata = {31'b0, r_cfg.peak_hold_enable};
            REG_HOLD_FRAMES:  prdata = {23'b0, r_cfg.hold_frames};
            REG_DECAY_STEP:   prdata = {23'b0, r_cfg.decay_step};
            REG_FFT_ORDER:    prdata = {28'b0, r_cfg.fft_order};
            REG_FIRST_OCT:    prdata = 32'(r_cfg.first_octave);
            REG_OCT_STEP:     prdata = {15'b0, r_cfg.octave_step};
            default:          prdata = '0;
        endcase
    end

endmodule

// ----- rtl/sbdb_front.sv -----
// Front part: bin counting, power, log2 by repeated squaring, dB level, tilt and
// the state-free half of the smoother product. A stall-free pipeline; uses sbdb_pkg.
module sbdb_front import sbdb_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_in_item i_item,
    input  t_cfg     i_cfg,
    output logic     o_valid,
    output t_mid     o_mid
);

    // Side data carried along the squaring stages.
    typedef struct packed {
        logic [BIN_W-1:0]   bin;
        logic               last;
        logic [5:0]         e;
        logic               zero;
        logic signed [23:0] tilt;
    } t_side;

    function automatic logic [3:0] lead16(input logic [15:0] x);
        logic [3:0] idx;
        idx = '0;
        for (int i = 0; i < 16; i++) begin
            if (x[i]) idx = 4'(i);
        end
        return idx;
    endfunction

    logic [BIN_W-1:0] r_bin_cnt;

    // Stage 1: captured item.
    logic                r1_v;
    logic signed [31:0]  r1_re, r1_im;
    logic [BIN_W-1:0]    r1_bin;
    logic                r1_last;

    // Stage 2: squares and octave position.
    logic                r2_v;
    logic [63:0]         r2_sq_re, r2_sq_im;
    logic signed [28:0]  r2_oct;
    logic [BIN_W-1:0]    r2_bin;
    logic                r2_last;

    // Stage 3: power and tilt product.
    logic                r3_v;
    logic [63:0]         r3_p;
    logic signed [39:0]  r3_tp;
    logic [BIN_W-1:0]    r3_bin;
    logic                r3_last;

    // Stage 4: leading one per 16-bit chunk, rounded tilt.
    logic                r4_v;
    logic [63:0]         r4_p;
    logic [3:0]          r4_nz;
    logic [3:0]          r4_idx [4];
    logic signed [23:0]  r4_tilt;
    logic [BIN_W-1:0]    r4_bin;
    logic                r4_last;

    // Squaring pipeline, entry 0 is the normalized mantissa.
    logic                r_sq_v [SQ_STEPS+1];
    logic [31:0]         r_sq_m [SQ_STEPS+1];
    logic [15:0]         r_sq_f [SQ_STEPS+1];
    t_side               r_sq_s [SQ_STEPS+1];

    // Stage 6: dB product; stage 7: level; stage 8: smoother premultiply.
    logic                r6_v;
    logic signed [49:0]  r6_prod;
    t_side               r6_s;
    logic                r7_v;
    logic signed [15:0]  r7_level;
    logic [BIN_W-1:0]    r7_bin;
    logic                r7_last;
    logic                r8_v;
    t_mid                r8_mid;

    logic [31:0]         w_ar, w_ai;
    logic [26:0]         w_bs;
    logic [5:0]          w_e;
    logic [94:0]         w_shift;
    logic signed [7:0]   w_ival;
    logic signed [23:0]  w_l;
    logic signed [17:0]  w_raw;
    logic signed [15:0]  w_lvl;
    logic signed [24:0]  w_tsum;
    logic signed [15:0]  w_tsat;
    logic [16:0]         w_omc;
    logic signed [39:0]  w_tr;

    assign w_ar = r1_re[31] ? (~r1_re + 32'd1) : r1_re;
    assign w_ai = r1_im[31] ? (~r1_im + 32'd1) : r1_im;
    assign w_bs = r1_bin * i_cfg.octave_step;

    // Bin counter, restarted by the frame end marker or after the last bin.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_cnt <= '0;
        end else if (i_accept) begin
            if (i_item.frame_end || (r_bin_cnt == BIN_W'(NUM_BINS - 1))) begin
                r_bin_cnt <= '0;
            end else begin
                r_bin_cnt <= r_bin_cnt + 1'b1;
            end
        end
    end

    // Valid bits of the fixed stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r6_v <= 1'b0;
            r7_v <= 1'b0;
            r8_v <= 1'b0;
        end else begin
            r1_v <= i_accept;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r6_v <= r_sq_v[SQ_STEPS];
            r7_v <= r6_v;
            r8_v <= r7_v;
        end
    end

    // Stages 1 to 3.
    always_ff @(posedge i_clk) begin
        r1_re    <= i_item.re_part;
        r1_im    <= i_item.im_part;
        r1_bin   <= r_bin_cnt;
        r1_last  <= i_item.frame_end;
        r2_sq_re <= w_ar * w_ar;
        r2_sq_im <= w_ai * w_ai;
        r2_oct   <= 29'(i_cfg.first_octave) + $signed({2'b0, w_bs});
        r2_bin   <= r1_bin;
        r2_last  <= r1_last;
        r3_p     <= r2_sq_re + r2_sq_im;
        r3_tp    <= r2_oct * i_cfg.slope_per_octave;
        r3_bin   <= r2_bin;
        r3_last  <= r2_last;
    end

    // Stage 4: chunk search for the highest set bit, tilt rounding.
    assign w_tr = r3_tp + 40'sd32768;
    always_ff @(posedge i_clk) begin
        r4_p    <= r3_p;
        r4_tilt <= w_tr[39:16];
        r4_bin  <= r3_bin;
        r4_last <= r3_last;
        for (int k = 0; k < 4; k++) begin
            r4_nz[k]  <= |r3_p[k*16 +: 16];
            r4_idx[k] <= lead16(r3_p[k*16 +: 16]);
        end
    end

    // Stage 5: exponent and normalization to Q1.31.
    always_comb begin
        priority if (r4_nz[3]) w_e = {2'd3, r4_idx[3]};
        else if (r4_nz[2])     w_e = {2'd2, r4_idx[2]};
        else if (r4_nz[1])     w_e = {2'd1, r4_idx[1]};
        else                   w_e = {2'd0, r4_idx[0]};
    end
    assign w_shift = {r4_p, 31'b0} >> w_e;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v[0] <= 1'b0;
        end else begin
            r_sq_v[0] <= r4_v;
        end
        r_sq_m[0]      <= w_shift[31:0];
        r_sq_f[0]      <= '0;
        r_sq_s[0].bin  <= r4_bin;
        r_sq_s[0].last <= r4_last;
        r_sq_s[0].e    <= w_e;
        r_sq_s[0].zero <= ~|r4_nz;
        r_sq_s[0].tilt <= r4_tilt;
    end

    // One squaring step per stage gives one fraction bit.
    for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sq
        logic [63:0] w_prod;
        assign w_prod = r_sq_m[g] * r_sq_m[g];
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[g+1] <= 1'b0;
            end else begin
                r_sq_v[g+1] <= r_sq_v[g];
            end
            r_sq_m[g+1] <= w_prod[63] ? w_prod[63:32] : w_prod[62:31];
            r_sq_f[g+1] <= {r_sq_f[g][14:0], w_prod[63]};
            r_sq_s[g+1] <= r_sq_s[g];
        end
    end

    // Stage 6: log2 with the 2/N offset, scaled to 1/128 dB.
    assign w_ival = $signed({2'b0, r_sq_s[SQ_STEPS].e}) + 8'sd2
                    - $signed({3'b0, i_cfg.fft_order, 1'b0});
    assign w_l    = {w_ival, r_sq_f[SQ_STEPS]};
    always_ff @(posedge i_clk) begin
        r6_prod <= w_l * LOG_K;
        r6_s    <= r_sq_s[SQ_STEPS];
    end

    // Stage 7: rounding, floor, tilt and saturation.
    always_comb begin
        logic signed [49:0] v_r;
        v_r   = r6_prod + 50'sd2147483648;
        w_raw = v_r[49:32];
        if (r6_s.zero || (w_raw < 18'(FLOOR_DB))) begin
            w_lvl = FLOOR_DB;
        end else begin
            w_lvl = w_raw[15:0];
        end
        w_tsum = 25'(w_lvl) + 25'(r6_s.tilt);
        priority if (w_tsum > 25'sd32767) w_tsat = 16'sd32767;
        else if (w_tsum < -25'sd32768)    w_tsat = -16'sd32768;
        else                              w_tsat = w_tsum[15:0];
    end

    always_ff @(posedge i_clk) begin
        r7_level <= w_tsat;
        r7_bin   <= r6_s.bin;
        r7_last  <= r6_s.last;
    end

    // Stage 8: level times (1 - c), the part of the smoother free of bin state.
    assign w_omc = 17'h10000 - {1'b0, i_cfg.smooth_coeff};
    always_ff @(posedge i_clk) begin
        r8_mid.bin     <= r7_bin;
        r8_mid.last    <= r7_last;
        r8_mid.level   <= r7_level;
        r8_mid.premult <= r7_level * $signed({1'b0, w_omc});
    end

    assign o_valid = r8_v;
    assign o_mid   = r8_mid;

endmodule

// ----- rtl/sbdb_queue.sv -----
// Short queue between the front and back parts.
// Uses t_mid and the depth constants from sbdb_pkg.
module sbdb_queue import sbdb_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_mid i_data,
    input  logic i_pop,
    output t_mid o_head,
    output logic o_empty
);

    t_mid              r_mem [MID_DEPTH];
    logic [MID_AW-1:0] r_wp, r_rp;
    logic [MID_AW:0]   r_cnt;

    assign o_head  = r_mem[r_rp];
    assign o_empty = (r_cnt == '0);

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (MID_AW+1)'(i_push) - (MID_AW+1)'(i_pop);
        end
    end

endmodule

// ----- rtl/sbdb_back.sv -----
// Back part: per-bin smoother and peak hold state in memories, clearing passes,
// and the result queue. Uses sbdb_pkg.
module sbdb_back import sbdb_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_peak_clr,
    input  t_mid    i_head,
    input  logic    i_mid_empty,
    output logic    o_mid_pop,
    output logic    o_clr_busy,
    input  logic    pop,
    output logic    empty,
    output t_result o_result
);

    logic signed [15:0] r_smem [NUM_BINS];
    logic signed [15:0] r_pmem [NUM_BINS];
    logic [8:0]         r_hmem [NUM_BINS];
    logic signed [15:0] r_sq, r_pq;
    logic [8:0]         r_hq;

    // Clearing pass.
    logic               r_clr_active, r_clr_all;
    logic [BIN_W-1:0]   r_clr_addr;

    // Update stage.
    logic               r_c_valid;
    t_mid               r_c;

    // Last written bin, for a read that overlapped its write.
    logic               r_fwd_valid;
    logic [BIN_W-1:0]   r_fwd_bin;
    logic signed [15:0] r_fwd_s, r_fwd_pk;
    logic [8:0]         r_fwd_hold;

    // Result queue.
    t_result            r_oq [OUT_DEPTH];
    logic [OUT_AW-1:0]  r_owp, r_orp;
    logic [OUT_AW:0]    r_ocnt;

    logic               w_fwd;
    logic signed [15:0] w_prev, w_pk_old, w_s, w_pk_new;
    logic [8:0]         w_hold_old, w_hold_new;
    logic signed [32:0] w_prod;
    logic signed [34:0] w_sum;
    logic signed [17:0] w_dec;
    logic               w_out_pop;
    t_result            w_res;

    assign o_clr_busy = r_clr_active;
    assign o_mid_pop  = !i_mid_empty && !r_clr_active
                        && ((r_ocnt + (OUT_AW+1)'(r_c_valid)) < (OUT_AW+1)'(OUT_DEPTH));
    assign empty      = (r_ocnt == '0);
    assign w_out_pop  = pop && !empty;
    assign o_result   = r_oq[r_orp];

    // Clearing pass control: all stores after reset, peaks only on request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_all    <= 1'b1;
            r_clr_addr   <= '0;
        end else if (i_peak_clr && !r_clr_active) begin
            r_clr_active <= 1'b1;
            r_clr_all    <= 1'b0;
            r_clr_addr   <= '0;
        end else if (r_clr_active) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == BIN_W'(NUM_BINS - 1)) r_clr_active <= 1'b0;
        end
    end

    // Smoother store.
    always_ff @(posedge i_clk) begin
        if (r_clr_active && r_clr_all) begin
            r_smem[r_clr_addr] <= FLOOR_DB;
        end else if (r_c_valid) begin
            r_smem[r_c.bin] <= w_s;
        end
        if (o_mid_pop) r_sq <= r_smem[i_head.bin];
    end

    // Peak store.
    always_ff @(posedge i_clk) begin
        if (r_clr_active) begin
            r_pmem[r_clr_addr] <= FLOOR_DB;
        end else if (r_c_valid) begin
            r_pmem[r_c.bin] <= w_pk_new;
        end
        if (o_mid_pop) r_pq <= r_pmem[i_head.bin];
    end

    // Hold count store.
    always_ff @(posedge i_clk) begin
        if (r_clr_active && r_clr_all) begin
            r_hmem[r_clr_addr] <= '0;
        end else if (r_c_valid) begin
            r_hmem[r_c.bin] <= w_hold_new;
        end
        if (o_mid_pop) r_hq <= r_hmem[i_head.bin];
    end

    // Update stage register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else begin
            r_c_valid <= o_mid_pop;
        end
        if (o_mid_pop) r_c <= i_head;
    end

    // Smoother and peak hold arithmetic.
    always_comb begin
        w_fwd      = r_fwd_valid && (r_fwd_bin == r_c.bin);
        w_prev     = w_fwd ? r_fwd_s    : r_sq;
        w_pk_old   = w_fwd ? r_fwd_pk   : r_pq;
        w_hold_old = w_fwd ? r_fwd_hold : r_hq;

        w_prod = w_prev * $signed({1'b0, i_cfg.smooth_coeff});
        w_sum  = 35'(w_prod) + 35'(r_c.premult) + 35'sd32768;
        if (i_cfg.smooth_coeff == '0) begin
            w_s = r_c.level;
        end else if ($signed(w_sum[34:16]) > 19'sd32767) begin
            w_s = 16'sd32767;
        end else if ($signed(w_sum[34:16]) < -19'sd32768) begin
            w_s = -16'sd32768;
        end else begin
            w_s = w_sum[31:16];
        end

        w_dec      = 18'(w_pk_old) - $signed({9'b0, i_cfg.decay_step});
        w_pk_new   = w_pk_old;
        w_hold_new = w_hold_old;
        if (i_cfg.peak_hold_enable) begin
            priority if (w_s > w_pk_old) begin
                w_pk_new   = w_s;
                w_hold_new = i_cfg.hold_frames;
            end else if (w_hold_old != '0) begin
                w_hold_new = w_hold_old - 1'b1;
            end else begin
                w_pk_new = (w_dec < 18'(w_s)) ? w_s : w_dec[15:0];
            end
        end

        w_res.bin_index  = r_c.bin;
        w_res.display_db = w_s;
        w_res.peak_db    = w_pk_new;
        w_res.frame_done = r_c.last;
    end

    // Forwarding copy of the last write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || r_clr_active) begin
            r_fwd_valid <= 1'b0;
        end else if (r_c_valid) begin
            r_fwd_valid <= 1'b1;
        end
        if (r_c_valid) begin
            r_fwd_bin  <= r_c.bin;
            r_fwd_s    <= w_s;
            r_fwd_pk   <= w_pk_new;
            r_fwd_hold <= w_hold_new;
        end
    end

    // Result queue.
    always_ff @(posedge i_clk) begin
        if (r_c_valid) r_oq[r_owp] <= w_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp  <= '0;
            r_orp  <= '0;
            r_ocnt <= '0;
        end else begin
            if (r_c_valid) r_owp <= r_owp + 1'b1;
            if (w_out_pop) r_orp <= r_orp + 1'b1;
            r_ocnt <= r_ocnt + (OUT_AW+1)'(r_c_valid) - (OUT_AW+1)'(w_out_pop);
        end
    end

endmodule

// ----- rtl/spectrum_bin_db_smoothing_peak_hold_top.sv -----
// Throughput: one item per cycle while full is low, set by the one-item-per-cycle
// squaring pipeline. Reset is synchronous; after it a clearing pass of the bin stores
// runs with full high. Writing 0 to the peak enable starts a peak clearing pass.
// Top level; instantiates sbdb_regs, sbdb_front, sbdb_queue and sbdb_back from sbdb_pkg.
module spectrum_bin_db_smoothing_peak_hold_top import sbdb_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  t_in_item    i_item,
    output logic        empty,
    input  logic        pop,
    output t_result     o_result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg            w_cfg;
    logic            w_peak_clr, w_accept, w_front_v, w_mid_pop, w_mid_empty, w_clr_busy;
    t_mid            w_front_mid, w_head;
    logic [MID_AW:0] r_pending;

    // Items taken but not yet moved to the back part; bounds the queue.
    assign full     = w_clr_busy || w_peak_clr
                      || (r_pending >= (MID_AW+1)'(MID_DEPTH));
    assign w_accept = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + (MID_AW+1)'(w_accept) - (MID_AW+1)'(w_mid_pop);
        end
    end

    sbdb_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_cfg      (w_cfg),
        .o_peak_clr (w_peak_clr)
    );

    sbdb_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_item   (i_item),
        .i_cfg    (w_cfg),
        .o_valid  (w_front_v),
        .o_mid    (w_front_mid)
    );

    sbdb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_front_v),
        .i_data  (w_front_mid),
        .i_pop   (w_mid_pop),
        .o_head  (w_head),
        .o_empty (w_mid_empty)
    );

    sbdb_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_peak_clr  (w_peak_clr),
        .i_head      (w_head),
        .i_mid_empty (w_mid_empty),
        .o_mid_pop   (w_mid_pop),
        .o_clr_busy  (w_clr_busy),
        .pop         (pop),
        .empty       (empty),
        .o_result    (o_result)
    );

    // The pending count never exceeds the queue depth.
    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= (MID_AW+1)'(MID_DEPTH))
        else $error("pending item count above queue depth");

    // No item is taken while a clearing pass runs.
    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clr_busy |-> !w_accept)
        else $error("item taken during clearing pass");

    // A filled queue implies counted pending items.
    a_queue_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_mid_empty |-> (r_pending != '0))
        else $error("queue holds an item that is not counted");

    // Nothing is moved to the back part during a clearing pass.
    a_no_pop_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clr_busy |-> !w_mid_pop)
        else $error("queue read during clearing pass");

endmodule

// ----- tb/tb_spectrum_bin_db_smoothing_peak_hold_top.sv -----
// Self-checking testbench for the spectrum bin level, smoothing and peak hold block.
// Needs sbdb_pkg and spectrum_bin_db_smoothing_peak_hold_top; it reads no files.
module tb_spectrum_bin_db_smoothing_peak_hold_top;
    import sbdb_pkg::*;

    localparam int  DRAIN_CYCLES = 60;
    localparam int  CYCLE_LIMIT  = 1000000;
    localparam int  LONG_FRAME   = 32;
    localparam longint FLOOR_LVL = -12800;
    localparam longint LOG_SCALE = 25252226;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    t_in_item    i_item;
    logic        empty;
    logic        pop;
    t_result     o_result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Predictor state: registers and per-bin stores.
    t_cfg        cfg_shadow;
    shortint     smooth_mem [NUM_BINS];
    shortint     peak_mem [NUM_BINS];
    int          hold_mem [NUM_BINS];
    int          bin_pos;

    t_result     pending_results [$];
    int          errors;
    int          items_sent;
    int          results_seen;
    int          cycle_count;
    int          pop_stall;
    bit          push_gaps_on;
    bit          pop_gaps_on;

    spectrum_bin_db_smoothing_peak_hold_top DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .push     (push),
        .full     (full),
        .i_item   (i_item),
        .empty    (empty),
        .pop      (pop),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Clock generation.
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Floor division by 2^s after adding half, as the level path rounds.
    function automatic longint round_half_up(longint x, int s);
        longint y;
        y = x + (longint'(1) << (s - 1));
        return y >>> s;
    endfunction

    function automatic longint clamp16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    // log2 of a nonzero power value in Q16 by repeated squaring.
    function automatic longint power_log2(logic [63:0] p);
        int          e;
        logic [63:0] m;
        logic [15:0] frac;
        e = 63;
        frac = '0;
        while (!p[e]) e--;
        if (e >= 31) m = p >> (e - 31);
        else m = p << (31 - e);
        for (int i = 0; i < 16; i++) begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= 64'h1_0000_0000) begin
                frac[0] = 1'b1;
                m = m >> 1;
            end
        end
        return longint'(e) * 65536 + longint'(frac);
    endfunction

    // Computes the result of one bin and advances the per-bin stores.
    function automatic t_result predict_bin(t_in_item it);
        t_result     r;
        longint      re, im, lvl, oct, s, pk, c, fo;
        logic [63:0] pwr;
        int          b;
        b = bin_pos;
        re = longint'($signed(it.re_part));
        im = longint'($signed(it.im_part));
        if (re < 0) re = -re;
        if (im < 0) im = -im;
        pwr = 64'(re) * 64'(re) + 64'(im) * 64'(im);
        fo = longint'(cfg_shadow.fft_order);
        if (pwr == 0) begin
            lvl = FLOOR_LVL;
        end else begin
            lvl = round_half_up((power_log2(pwr) + (2 - 2 * fo) * 65536) * LOG_SCALE, 32);
            if (lvl < FLOOR_LVL) lvl = FLOOR_LVL;
        end
        if (cfg_shadow.slope_per_octave != 0) begin
            oct = longint'($signed(cfg_shadow.first_octave))
                + longint'(b) * longint'(cfg_shadow.octave_step);
            lvl += round_half_up(oct * longint'($signed(cfg_shadow.slope_per_octave)), 16);
        end
        lvl = clamp16(lvl);
        if (cfg_shadow.smooth_coeff != 0) begin
            c = longint'(cfg_shadow.smooth_coeff);
            s = clamp16(round_half_up(longint'(smooth_mem[b]) * c + lvl * (65536 - c), 16));
        end else begin
            s = lvl;
        end
        smooth_mem[b] = shortint'(s);
        if (cfg_shadow.peak_hold_enable) begin
            pk = longint'(peak_mem[b]);
            if (s > pk) begin
                peak_mem[b] = shortint'(s);
                hold_mem[b] = int'(cfg_shadow.hold_frames);
            end else if (hold_mem[b] > 0) begin
                hold_mem[b]--;
            end else begin
                pk -= longint'(cfg_shadow.decay_step);
                if (pk < s) pk = s;
                peak_mem[b] = shortint'(pk);
            end
        end
        r.bin_index  = b[BIN_W-1:0];
        r.display_db = s[15:0];
        r.peak_db    = peak_mem[b];
        r.frame_done = it.frame_end;
        bin_pos = it.frame_end ? 0 : (b + 1) % NUM_BINS;
        return r;
    endfunction

    // Sends one item: optional gap, then hold push until the transfer happens.
    task automatic send_bin(logic [31:0] re, logic [31:0] im, logic last);
        int gap;
        gap = push_gaps_on ? $urandom_range(0, 16) : 0;
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1'b1;
        i_item.re_part   <= re;
        i_item.im_part   <= im;
        i_item.frame_end <= last;
        do @(posedge i_clk); while (full);
        pending_results.push_back(predict_bin('{re, im, last}));
        items_sent++;
    endtask

    // Random bin value: full-range words, scaled values or exact zero.
    function automatic logic [31:0] random_part();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return '0;
        if (pick < 4) return $urandom;
        return 32'($signed($urandom) >>> $urandom_range(0, 31));
    endfunction

    // One register write over the configuration port, setup then access.
    task automatic write_reg(logic [2:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_SMOOTH_COEFF: cfg_shadow.smooth_coeff     = value[15:0];
            REG_SLOPE:        cfg_shadow.slope_per_octave = value[10:0];
            REG_PEAK_EN: begin
                cfg_shadow.peak_hold_enable = value[0];
                if (!value[0]) begin
                    for (int i = 0; i < NUM_BINS; i++) peak_mem[i] = FLOOR_DB;
                end
            end
            REG_HOLD_FRAMES:  cfg_shadow.hold_frames  = value[8:0];
            REG_DECAY_STEP:   cfg_shadow.decay_step   = value[8:0];
            REG_FFT_ORDER:    cfg_shadow.fft_order    = value[3:0];
            REG_FIRST_OCT:    cfg_shadow.first_octave = value[20:0];
            REG_OCT_STEP:     cfg_shadow.octave_step  = value[16:0];
            default: ;
        endcase
    endtask

    // Waits for every expected result, then lets the pipeline settle.
    task automatic wait_drained();
        push <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_all(logic [15:0] coeff, logic [10:0] slope, logic en,
                             logic [8:0] hold, logic [8:0] decay, logic [3:0] order,
                             logic [20:0] first, logic [16:0] step);
        write_reg(REG_SMOOTH_COEFF, 32'(coeff));
        write_reg(REG_SLOPE, 32'($signed(slope)));
        write_reg(REG_HOLD_FRAMES, 32'(hold));
        write_reg(REG_DECAY_STEP, 32'(decay));
        write_reg(REG_FFT_ORDER, 32'(order));
        write_reg(REG_FIRST_OCT, 32'($signed(first)));
        write_reg(REG_OCT_STEP, 32'(step));
        write_reg(REG_PEAK_EN, 32'(en));
    endtask

    // Field extremes and the zero-power case, first under the reset settings, then under one written setting.
    task automatic test_directed_extremes();
        push_gaps_on = 1'b0;
        send_bin(32'h0, 32'h0, 1'b0);
        send_bin(32'h8000_0000, 32'h8000_0000, 1'b0);
        send_bin(32'h7FFF_FFFF, 32'h0, 1'b0);
        send_bin(32'h0, 32'h8000_0000, 1'b0);
        send_bin(32'h1, 32'h0, 1'b0);
        send_bin(32'hFFFF_FFFF, 32'h1, 1'b1);
        send_bin(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_bin(32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
        send_bin(32'hAAAA_AAAA, 32'h5555_5555, 1'b1);
        wait_drained();
        write_all(16'd62259, 11'sd576, 1'b1, 9'd15, 9'd256, 4'd4, 21'h0FFFFF, 17'd65536);
        push_gaps_on = 1'b1;
        send_bin(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        send_bin(32'h0, 32'h0, 1'b0);
        send_bin(32'h8000_0000, 32'h1, 1'b1);
        send_bin(32'h1234_5678, 32'h0, 1'b0);
        send_bin(32'h0, 32'h0, 1'b1);
        wait_drained();
    endtask

    // Short frames under many register settings; loud bursts drive the peak hold.
    task automatic test_settings_sweep();
        int   frame_len, idx;
        logic last;
        for (int ph = 0; ph < 9; ph++) begin
            case (ph)
                0: write_all(16'd0, 11'sd0, 1'b1, 9'd15, 9'd13, 4'd12, 21'd0, 17'd0);
                1: write_all(16'd62259, -11'sd576, 1'b1, 9'd300, 9'd256, 4'd15,
                             21'h100000, 17'd0);
                2: write_all(16'd1, 11'sd576, 1'b1, 9'd15, 9'd256, 4'd4, 21'h0FFFFF, 17'd1);
                3: write_all(16'd65535, 11'h7FF, 1'b0, 9'd0, 9'd511, 4'd0, 21'h1FFFFF,
                             17'h1FFFF);
                4: write_all(16'd32768, -11'sd1024, 1'b1, 9'd511, 9'd0, 4'd15, 21'd0,
                             17'd65536);
                default: write_all(16'($urandom_range(0, 62259)),
                                   11'($signed($urandom_range(0, 1152)) - 576), 1'b1,
                                   9'($urandom_range(15, 300)), 9'($urandom_range(13, 256)),
                                   4'($urandom_range(4, 15)),
                                   21'($urandom), 17'($urandom_range(0, 65536)));
            endcase
            push_gaps_on = $urandom_range(0, 2) != 0;
            pop_gaps_on  = $urandom_range(0, 2) != 0;
            frame_len = $urandom_range(2, 6);
            idx = 0;
            for (int n = 0; n < 45; n++) begin
                last = (idx == frame_len - 1);
                if ($urandom_range(0, 19) == 0) last = $urandom_range(0, 1);
                if ($urandom_range(0, 7) == 0)
                    send_bin(32'h7FFF_FFFF >> $urandom_range(0, 3), random_part(), last);
                else
                    send_bin(random_part(), random_part(), last);
                idx = last ? 0 : idx + 1;
            end
            wait_drained();
        end
    endtask

    // One long frame sent back to back with a steep tilt across the bins.
    task automatic test_long_frame();
        write_all(16'd40000, 11'sd300, 1'b1, 9'd20, 9'd100, 4'd10, 21'h1F0000, 17'd4096);
        push_gaps_on = 1'b0;
        pop_gaps_on  = 1'b0;
        for (int n = 0; n < LONG_FRAME; n++) send_bin(random_part(), random_part(), 1'b0);
        send_bin(random_part(), random_part(), 1'b1);
        wait_drained();
    endtask

    // Result checker and receiver-side stalls.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (pop && !empty) begin
                results_seen++;
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result, actual %p", $time, o_result);
                    errors++;
                end else begin
                    if (o_result.bin_index !== pending_results[0].bin_index) begin
                        $display("%0t: bin_index expected %0d actual %0d", $time,
                                 pending_results[0].bin_index, o_result.bin_index);
                        errors++;
                    end
                    if (o_result.display_db !== pending_results[0].display_db) begin
                        $display("%0t: display_db expected %0d actual %0d", $time,
                                 pending_results[0].display_db, o_result.display_db);
                        errors++;
                    end
                    if (o_result.peak_db !== pending_results[0].peak_db) begin
                        $display("%0t: peak_db expected %0d actual %0d", $time,
                                 pending_results[0].peak_db, o_result.peak_db);
                        errors++;
                    end
                    if (o_result.frame_done !== pending_results[0].frame_done) begin
                        $display("%0t: frame_done expected %0d actual %0d", $time,
                                 pending_results[0].frame_done, o_result.frame_done);
                        errors++;
                    end
                    void'(pending_results.pop_front());
                end
                pop_stall = pop_gaps_on ? $urandom_range(0, 16) : 0;
                pop <= (pop_stall == 0);
            end else if (!pop) begin
                if (pop_stall > 0) pop_stall--;
                else pop <= 1'b1;
            end
        end
    end

    // Timeout guard.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_spectrum_bin_db_smoothing_peak_hold_top failed");
            $finish;
        end
    end

    // Test sequence.
    initial begin
        push    <= 1'b0;
        i_item  <= '0;
        pop     <= 1'b0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        i_rst_n <= 1'b0;
        errors = 0;
        items_sent = 0;
        results_seen = 0;
        cycle_count = 0;
        pop_stall = 0;
        push_gaps_on = 1'b1;
        pop_gaps_on = 1'b1;
        bin_pos = 0;
        cfg_shadow = '0;
        cfg_shadow.hold_frames = 9'd60;
        cfg_shadow.decay_step  = 9'd64;
        cfg_shadow.fft_order   = 4'd12;
        for (int i = 0; i < NUM_BINS; i++) begin
            smooth_mem[i] = FLOOR_DB;
            peak_mem[i]   = FLOOR_DB;
            hold_mem[i]   = 0;
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_extremes();
        test_settings_sweep();
        test_long_frame();

        $display("Sent %0d bins and checked %0d results over a sweep of register settings,",
                 items_sent, results_seen);
        $display("including peak clears, out-of-range registers and a long unbroken frame.");
        if (errors == 0 && pending_results.size() == 0) begin
            $display("tb_spectrum_bin_db_smoothing_peak_hold_top passed");
        end else begin
            $display("tb_spectrum_bin_db_smoothing_peak_hold_top failed");
        end
        $finish;
    end

endmodule
